@@ rtl/core/rvse_pkg.sv @@
// Shared definitions for the RV32I subset execute block.
// Opcodes, function codes, ALU control codes and the structs passed
// between the register file, the execute logic and the top level.
`default_nettype none

package rvse_pkg;

  localparam int DefRegCount = 32;
  localparam int XLen        = 32;
  localparam int RegIdxW     = 5;
  localparam int BrOffW      = 13;

  localparam logic [6:0] OP_RTYPE  = 7'b0110011;
  localparam logic [6:0] OP_ITYPE  = 7'b0010011;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  localparam logic [2:0] F3_ADD = 3'b000;
  localparam logic [2:0] F3_BEQ = 3'b000;
  localparam logic [2:0] F3_OR  = 3'b110;
  localparam logic [2:0] F3_AND = 3'b111;

  // Classic ALU control encoding.
  typedef enum logic [3:0] {
    ALU_AND = 4'b0000,
    ALU_OR  = 4'b0001,
    ALU_ADD = 4'b0010,
    ALU_SUB = 4'b0110
  } alu_op_t;

  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] addr;
    logic [XLen-1:0]    data;
  } wr_req_t;

  typedef struct packed {
    logic               illegal_instr;
    logic [BrOffW-1:0]  branch_offset;
    logic               branch_taken;
    logic [XLen-1:0]    write_value;
    logic [RegIdxW-1:0] dest_reg;
    logic               writes_reg;
  } exec_res_t;

endpackage

`default_nettype wire

@@ rtl/core/rvse_regfile.sv @@
// Register file: synchronous memory with two registered read ports and one
// write port, per-entry valid bits for reset, and forwarding of the last write.
// Depends on rvse_pkg.
`default_nettype none

module rvse_regfile #(
  parameter int REG_COUNT = rvse_pkg::DefRegCount
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             rd_en,
  input  wire logic [rvse_pkg::RegIdxW-1:0]     rs1,
  input  wire logic [rvse_pkg::RegIdxW-1:0]     rs2,
  input  wire rvse_pkg::wr_req_t                wr,
  output logic      [rvse_pkg::XLen-1:0]        rdata1,
  output logic      [rvse_pkg::XLen-1:0]        rdata2
);
  import rvse_pkg::*;

  localparam int AddrW = $clog2(REG_COUNT);
  localparam logic [RegIdxW:0] RegLimit = (RegIdxW+1)'(REG_COUNT);

  logic [XLen-1:0]      mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid;

  logic [XLen-1:0]    q1;
  logic [XLen-1:0]    q2;
  logic               v1;
  logic               v2;
  logic [RegIdxW-1:0] idx1;
  logic [RegIdxW-1:0] idx2;
  wr_req_t            last_wr;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AddrW-1:0]] <= wr.data;
    end
    if (rd_en) begin
      q1   <= mem[rs1[AddrW-1:0]];
      q2   <= mem[rs2[AddrW-1:0]];
      idx1 <= rs1;
      idx2 <= rs2;
    end
  end

  // Entry zero is never written, so its valid bit keeps x0 reading as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      last_wr.en <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr[AddrW-1:0]] <= 1'b1;
        last_wr                   <= wr;
      end
      if (rd_en) begin
        v1 <= ({1'b0, rs1} < RegLimit) && valid[rs1[AddrW-1:0]];
        v2 <= ({1'b0, rs2} < RegLimit) && valid[rs2[AddrW-1:0]];
      end
    end
  end

  // A read taken at the same edge as a write sees the old entry; the most
  // recent write is always at least as new as the memory, so it wins on a hit.
  always_comb begin
    if (last_wr.en && last_wr.addr == idx1) begin
      rdata1 = last_wr.data;
    end else begin
      rdata1 = v1 ? q1 : '0;
    end
    if (last_wr.en && last_wr.addr == idx2) begin
      rdata2 = last_wr.data;
    end else begin
      rdata2 = v2 ? q2 : '0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rvse_exec.sv @@
// Decode and execute for add, sub, and, or, addi, andi, ori and beq.
// Produces the result item and the register write request. Depends on rvse_pkg.
`default_nettype none

module rvse_exec #(
  parameter int REG_COUNT = rvse_pkg::DefRegCount
) (
  input  wire logic [rvse_pkg::XLen-1:0] instr,
  input  wire logic [rvse_pkg::XLen-1:0] rdata1,
  input  wire logic [rvse_pkg::XLen-1:0] rdata2,
  output rvse_pkg::exec_res_t            res
);
  import rvse_pkg::*;

  localparam logic [RegIdxW:0] RegLimit = (RegIdxW+1)'(REG_COUNT);

  logic [6:0]         opc;
  logic [2:0]         f3;
  logic [6:0]         f7;
  logic [RegIdxW-1:0] rd;
  logic [RegIdxW-1:0] rs1;
  logic [RegIdxW-1:0] rs2;
  logic               rd_ok;
  logic               rs1_ok;
  logic               rs2_ok;
  logic [XLen-1:0]    imm_i;
  logic [BrOffW-1:0]  imm_b;
  logic [XLen-1:0]    opb;
  logic [XLen-1:0]    alu_out;
  alu_op_t            alu_op;
  logic               illegal;
  logic               is_alu;
  logic               is_br;

  assign opc    = instr[6:0];
  assign rd     = instr[11:7];
  assign f3     = instr[14:12];
  assign rs1    = instr[19:15];
  assign rs2    = instr[24:20];
  assign f7     = instr[31:25];
  assign rd_ok  = {1'b0, rd} < RegLimit;
  assign rs1_ok = {1'b0, rs1} < RegLimit;
  assign rs2_ok = {1'b0, rs2} < RegLimit;
  assign imm_i  = {{(XLen-12){instr[31]}}, instr[31:20]};
  assign imm_b  = {instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};

  always_comb begin
    illegal = 1'b0;
    is_alu  = 1'b0;
    is_br   = 1'b0;
    alu_op  = ALU_ADD;
    opb     = rdata2;
    unique case (opc)
      OP_RTYPE: begin
        is_alu = 1'b1;
        if (!rs1_ok || !rs2_ok || !rd_ok) begin
          illegal = 1'b1;
        end else if (f7 == F7_BASE && f3 == F3_ADD) begin
          alu_op = ALU_ADD;
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          alu_op = ALU_SUB;
        end else if (f7 == F7_BASE && f3 == F3_AND) begin
          alu_op = ALU_AND;
        end else if (f7 == F7_BASE && f3 == F3_OR) begin
          alu_op = ALU_OR;
        end else begin
          illegal = 1'b1;
        end
      end
      OP_ITYPE: begin
        is_alu = 1'b1;
        opb    = imm_i;
        if (!rs1_ok || !rd_ok) begin
          illegal = 1'b1;
        end else if (f3 == F3_ADD) begin
          alu_op = ALU_ADD;
        end else if (f3 == F3_AND) begin
          alu_op = ALU_AND;
        end else if (f3 == F3_OR) begin
          alu_op = ALU_OR;
        end else begin
          illegal = 1'b1;
        end
      end
      OP_BRANCH: begin
        is_br = 1'b1;
        if (f3 != F3_BEQ || !rs1_ok || !rs2_ok) begin
          illegal = 1'b1;
        end
      end
      default: begin
        illegal = 1'b1;
      end
    endcase
  end

  always_comb begin
    unique case (alu_op)
      ALU_ADD: alu_out = rdata1 + opb;
      ALU_SUB: alu_out = rdata1 - opb;
      ALU_AND: alu_out = rdata1 & opb;
      ALU_OR:  alu_out = rdata1 | opb;
      default: alu_out = rdata1 + opb;
    endcase
  end

  // A result aimed at x0 is dropped entirely.
  always_comb begin
    res.writes_reg    = is_alu && !illegal && (rd != '0);
    res.dest_reg      = res.writes_reg ? rd : '0;
    res.write_value   = res.writes_reg ? alu_out : '0;
    res.branch_taken  = is_br && !illegal && (rdata1 == rdata2);
    res.branch_offset = (is_br && !illegal) ? imm_b : '0;
    res.illegal_instr = illegal;
  end

endmodule

`default_nettype wire

@@ rtl/core/rv32_subset_execute.sv @@
// An accepted request enters stage s1 with its register file read; its result
// is registered when s1 fires. Throughput: one instruction per cycle unless the
// output stalls; the last write is forwarded, so dependent instructions never
// wait. Reset clears the register file's valid bits; every register reads as
// zero right after reset. Depends on rvse_pkg, rvse_regfile, rvse_exec.
`default_nettype none

module rv32_subset_execute #(
  parameter int REG_COUNT = rvse_pkg::DefRegCount
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // [31:0] instr_word
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] writes_reg, [5:1] dest_reg, [37:6] write_value, [38] branch_taken,
  // [51:39] branch_offset, [52] illegal_instr, [55:53] zero
  output logic [55:0]      m_tdata
);
  import rvse_pkg::*;

  logic            s1_valid;
  logic [XLen-1:0] s1_instr;
  logic            s1_fire;
  logic            accept;
  logic [XLen-1:0] rdata1;
  logic [XLen-1:0] rdata2;
  exec_res_t       res;
  exec_res_t       out_res;
  wr_req_t         wr;

  assign s1_fire  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_fire;
  assign accept   = s_tvalid && s_tready;

  assign wr.en   = s1_fire && res.writes_reg;
  assign wr.addr = res.dest_reg;
  assign wr.data = res.write_value;

  rvse_regfile #(
    .REG_COUNT(REG_COUNT)
  ) u_regfile (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rs1    (s_tdata[19:15]),
    .rs2    (s_tdata[24:20]),
    .wr     (wr),
    .rdata1 (rdata1),
    .rdata2 (rdata2)
  );

  rvse_exec #(
    .REG_COUNT(REG_COUNT)
  ) u_exec (
    .instr  (s1_instr),
    .rdata1 (rdata1),
    .rdata2 (rdata2),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (s1_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_instr <= s_tdata;
    end
    if (s1_fire) begin
      out_res <= res;
    end
  end

  assign m_tdata = {3'b000, out_res};

endmodule

`default_nettype wire

@@ rtl/core/rvse_checker.sv @@
// Port-level checks for rv32_subset_execute, attached by a bind statement.
// Depends only on the top level's ports.
`default_nettype none

module rvse_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata
);

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // An illegal instruction reports nothing else.
  a_illegal_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[52] |-> m_tdata[51:0] == 52'd0)
    else $error("illegal instruction carries results");

  // A write never targets x0 or comes with a taken branch, and no write means no destination or value.
  a_write_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] && m_tdata[5:1] != 5'd0 && !m_tdata[38])
              || (!m_tdata[0] && m_tdata[37:1] == 37'd0))
    else $error("write-back fields inconsistent");

  // A request accepted with no result held at the output is followed by m_tvalid.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
    else $error("result did not appear");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind rv32_subset_execute rvse_checker u_rvse_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
